### design/sslim_pkg.sv
// Shared constants and types for the stick setpoint slew limiter.
package sslim_pkg;

    // Timing and stick scaling
    localparam int TICK_HZ        = 1000;
    localparam int FALLBACK_TICKS = 20;
    localparam int CENTRE_US      = 1500;
    localparam int SPAN_US        = 500;

    // Field widths
    localparam int PULSE_W  = 12;
    localparam int TICKS_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int DB_W     = 8;
    localparam int MAXANG_W = 15;
    localparam int SLEW_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Shared multiplier and divider sizing
    localparam int MUL_W      = 16;
    localparam int DIVIDEND_W = 2 * MUL_W;
    localparam int HZ_BITS    = $clog2(TICK_HZ + 1);
    localparam int SPAN_BITS  = $clog2(SPAN_US + 1);
    localparam int DIVISOR_W  = (HZ_BITS > SPAN_BITS) ? HZ_BITS : SPAN_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam int MAG_W      = SPAN_BITS;
    // Step limit saturates here; any target difference fits below it
    localparam int STEP_W     = ANGLE_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_US   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE     = 2'd3;

    // Configuration reset values
    localparam logic [DB_W-1:0]     DEADBAND_RST  = 8'd25;
    localparam logic [MAXANG_W-1:0] MAX_ANGLE_RST = 15'd7680;
    localparam logic [SLEW_W-1:0]   SLEW_RATE_RST = 16'd20480;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIVGO = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Which quantity the shared unit is working on
    typedef enum logic [1:0] {
        PH_STEP  = 2'd0,
        PH_ROLL  = 2'd1,
        PH_PITCH = 2'd2
    } phase_t;

endpackage

### design/sslim_div.sv
// Restoring divider, one quotient bit per cycle.
module sslim_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [sslim_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [sslim_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                 done,
    output logic [sslim_pkg::DIVIDEND_W-1:0]     quotient
);
    import sslim_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    count_reg, count_next;
    logic [DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]    dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0]   quo_reg, quo_next;

    logic [DIVISOR_W:0]      shifted;
    logic [DIVISOR_W:0]      diff;
    logic                    fits;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    // Advance one bit per cycle
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = DIV_CNT_W'(DIVIDEND_W);
            rem_next   = '0;
            dsr_next   = divisor;
            quo_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && count_reg == DIV_CNT_W'(1) |=> done_reg)
        else $error("divider missed its done pulse");
`endif

endmodule

### design/stick_setpoint_slew_limiter.sv
// Top level: stick deadband, rescale and slew limiting over one shared mul/div unit.
// With assist on, the bit-serial divider runs three times (step limit, roll, pitch);
// with assist off the arithmetic is skipped and the held targets go straight out.
// A new sample is taken only once the previous result sits in the output register,
// so one stalled result does not block the next sample.
// Reset (rst_n, async, active low): targets zero, registers to their defaults.
module stick_setpoint_slew_limiter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [sslim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sslim_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Stick sample input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // roll_pulse_us[11:0], pitch_pulse_us[23:12], elapsed_ticks[39:24]
    input  logic [sslim_pkg::IN_DATA_W-1:0]   s_tdata,
    // Setpoint output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // roll_setpoint[15:0], pitch_setpoint[31:16]
    output logic [sslim_pkg::OUT_DATA_W-1:0]  m_tdata,
    // assist_active[0]
    output logic                              m_tuser
);
    import sslim_pkg::*;

    // Configuration registers
    logic                    assist_enable_reg;
    logic [DB_W-1:0]         deadband_reg;
    logic [MAXANG_W-1:0]     max_angle_reg;
    logic [SLEW_W-1:0]       slew_rate_reg;

    // Sequencer and working registers
    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [PULSE_W-1:0]      roll_pulse_reg, pitch_pulse_reg;
    logic [TICKS_W-1:0]      ticks_reg;
    logic [DIVIDEND_W-1:0]   product_reg;
    logic [DIVISOR_W-1:0]    divisor_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [ANGLE_W-1:0] roll_target_reg, pitch_target_reg;
    logic                    active_reg;
    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_user_reg;

    // Divider link
    logic                    div_start;
    logic                    div_done;
    logic [DIVIDEND_W-1:0]   div_quotient;

    // Stick front end
    logic [PULSE_W-1:0]      pulse_sel;
    logic                    off_pos;
    logic [PULSE_W-1:0]      mag_raw;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        excess;
    logic [MUL_W-1:0]        mul_a, mul_b;

    // Slew update
    logic [ANGLE_W-1:0]          want_mag;
    logic signed [ANGLE_W:0]     want;
    logic signed [ANGLE_W-1:0]   cur;
    logic signed [ANGLE_W+1:0]   delta, delta_lim, step_s, sum;
    logic [STEP_W-1:0]           step_sat;

    logic in_fire;
    logic out_load;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // Centre, clamp and remove the deadband from the selected pulse
    always_comb
    begin
        pulse_sel = (phase_reg == PH_PITCH) ? pitch_pulse_reg : roll_pulse_reg;
        off_pos   = pulse_sel >= PULSE_W'(CENTRE_US);
        mag_raw   = off_pos ? pulse_sel - PULSE_W'(CENTRE_US)
                            : PULSE_W'(CENTRE_US) - pulse_sel;
        mag       = (mag_raw > PULSE_W'(SPAN_US)) ? MAG_W'(SPAN_US) : mag_raw[MAG_W-1:0];
        excess    = (mag > MAG_W'(deadband_reg)) ? mag - MAG_W'(deadband_reg) : '0;
    end

    // Select operands for the shared multiplier
    always_comb
    begin
        case (phase_reg)
            PH_STEP:
            begin
                mul_a = slew_rate_reg;
                mul_b = ticks_reg;
            end
            PH_ROLL, PH_PITCH:
            begin
                mul_a = MUL_W'(excess);
                mul_b = MUL_W'(max_angle_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Move the current target toward its desired angle by at most the step
    always_comb
    begin
        want_mag  = div_quotient[ANGLE_W-1:0];
        want      = (neg_reg ^ (phase_reg == PH_PITCH))
                    ? -$signed({1'b0, want_mag}) : $signed({1'b0, want_mag});
        cur       = (phase_reg == PH_PITCH) ? pitch_target_reg : roll_target_reg;
        delta     = (ANGLE_W+2)'(want) - (ANGLE_W+2)'(cur);
        step_s    = $signed({1'b0, step_reg});
        if (delta > step_s)
            delta_lim = step_s;
        else if (delta < -step_s)
            delta_lim = -step_s;
        else
            delta_lim = delta;
        sum       = (ANGLE_W+2)'(cur) + delta_lim;
        step_sat  = (|div_quotient[DIVIDEND_W-1:STEP_W]) ? '1
                                                         : div_quotient[STEP_W-1:0];
    end

    // Sequence: step limit, then roll, then pitch through the shared unit; skipped with assist off
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    phase_next = PH_STEP;
                    state_next = assist_enable_reg ? S_MUL : S_DONE;
                end
            end
            S_MUL:
                state_next = S_DIVGO;
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_STEP:
                        begin
                            phase_next = PH_ROLL;
                            state_next = S_MUL;
                        end
                        PH_ROLL:
                        begin
                            phase_next = PH_PITCH;
                            state_next = S_MUL;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assist_enable_reg <= 1'b0;
            deadband_reg      <= DEADBAND_RST;
            max_angle_reg     <= MAX_ANGLE_RST;
            slew_rate_reg     <= SLEW_RATE_RST;
            state_reg         <= S_IDLE;
            phase_reg         <= PH_STEP;
            roll_target_reg   <= '0;
            pitch_target_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ASSIST_ENABLE: assist_enable_reg <= cfg_data[0];
                    CFG_DEADBAND_US:   deadband_reg      <= cfg_data[DB_W-1:0];
                    CFG_MAX_ANGLE:     max_angle_reg     <= cfg_data[MAXANG_W-1:0];
                    CFG_SLEW_RATE:     slew_rate_reg     <= cfg_data[SLEW_W-1:0];
                    default: ;
                endcase
            end

            if (state_reg == S_DIV && div_done && phase_reg == PH_ROLL)
                roll_target_reg <= sum[ANGLE_W-1:0];
            if (state_reg == S_DIV && div_done && phase_reg == PH_PITCH)
                pitch_target_reg <= sum[ANGLE_W-1:0];

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            roll_pulse_reg  <= s_tdata[PULSE_W-1:0];
            pitch_pulse_reg <= s_tdata[2*PULSE_W-1:PULSE_W];
            ticks_reg       <= (s_tdata[IN_DATA_W-1:2*PULSE_W] == '0)
                               ? TICKS_W'(FALLBACK_TICKS)
                               : s_tdata[IN_DATA_W-1:2*PULSE_W];
            active_reg      <= assist_enable_reg;
        end
        if (state_reg == S_MUL)
        begin
            product_reg <= mul_a * mul_b;
            neg_reg     <= !off_pos;
            divisor_reg <= (phase_reg == PH_STEP)
                           ? DIVISOR_W'(TICK_HZ)
                           : DIVISOR_W'(SPAN_US) - DIVISOR_W'(deadband_reg);
        end
        if (state_reg == S_DIV && div_done && phase_reg == PH_STEP)
            step_reg <= step_sat;
        if (out_load)
        begin
            out_data_reg <= {pitch_target_reg, roll_target_reg};
            out_user_reg <= active_reg;
        end
    end

    sslim_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !assist_enable_reg |=> state_reg == S_DONE)
        else $error("disabled assist did not skip the arithmetic");
    a_targets_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(roll_target_reg) && $stable(pitch_target_reg))
        else $error("targets changed while idle");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the wait state");
    a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid && state_reg == S_IDLE)
        else $error("result not presented after load");
`endif

endmodule

### tb/stick_setpoint_slew_limiter_tb.sv
`timescale 1ns / 100ps
// Testbench for the stick setpoint slew limiter: directed and random stick samples checked against a predictor.
module stick_setpoint_slew_limiter_tb;
    import sslim_pkg::*;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic                      active;
    } setpoint_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // Block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // roll_pulse_us[11:0], pitch_pulse_us[23:12], elapsed_ticks[39:24]
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // roll_setpoint[15:0], pitch_setpoint[31:16]
    logic [OUT_DATA_W-1:0] m_tdata;
    // assist_active[0]
    logic                  m_tuser;

    // Predictor copy of the registers and targets
    logic                      assist_on;
    logic [DB_W-1:0]           deadband;
    logic [MAXANG_W-1:0]       angle_limit;
    logic [SLEW_W-1:0]         slew_per_sec;
    logic signed [ANGLE_W-1:0] roll_tgt;
    logic signed [ANGLE_W-1:0] pitch_tgt;

    setpoint_t pending_setpoints[$];

    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left     = 0;

    stick_setpoint_slew_limiter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // Desired angle for one pulse: center, clamp, deadband, rescale
    function automatic longint stick_angle(logic [PULSE_W-1:0] pulse);
        longint off;
        longint mag;
        longint res;
        bit     neg;
        off = longint'(pulse) - CENTRE_US;
        neg = (off < 0);
        if (off > SPAN_US)
            off = SPAN_US;
        if (off < -SPAN_US)
            off = -SPAN_US;
        mag = neg ? -off : off;
        if (mag <= longint'(deadband))
            return 0;
        res = ((mag - longint'(deadband)) * longint'(angle_limit))
              / (SPAN_US - longint'(deadband));
        if (res > longint'(angle_limit))
            res = longint'(angle_limit);
        return neg ? -res : res;
    endfunction

    // Move one target toward its desired angle by at most the step limit
    function automatic logic signed [ANGLE_W-1:0] slew_toward(
        logic signed [ANGLE_W-1:0] cur, longint want, longint step);
        longint                    d;
        logic signed [ANGLE_W-1:0] nxt;
        d = want - longint'(cur);
        if (d > step)
            d = step;
        if (d < -step)
            d = -step;
        nxt = ANGLE_W'(longint'(cur) + d);
        return nxt;
    endfunction

    // Advance the predicted targets by one accepted sample
    function automatic setpoint_t advance_setpoints(logic [PULSE_W-1:0] roll,
        logic [PULSE_W-1:0] pitch, logic [TICKS_W-1:0] ticks);
        longint    t;
        longint    step;
        setpoint_t sp;
        t = longint'(ticks);
        if (t == 0)
            t = FALLBACK_TICKS;
        step = (longint'(slew_per_sec) * t) / TICK_HZ;
        if (assist_on)
        begin
            roll_tgt  = slew_toward(roll_tgt, stick_angle(roll), step);
            pitch_tgt = slew_toward(pitch_tgt, -stick_angle(pitch), step);
        end
        sp.roll   = roll_tgt;
        sp.pitch  = pitch_tgt;
        sp.active = assist_on;
        return sp;
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        setpoint_t want;
        setpoint_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.roll   = m_tdata[ANGLE_W-1:0];
            got.pitch  = m_tdata[2*ANGLE_W-1:ANGLE_W];
            got.active = m_tuser;
            results_seen++;
            if (pending_setpoints.size() == 0)
                report_error($sformatf("unexpected result roll %0d pitch %0d active %0b",
                                       got.roll, got.pitch, got.active));
            else
            begin
                want = pending_setpoints.pop_front();
                if (got.roll !== want.roll || got.pitch !== want.pitch ||
                    got.active !== want.active)
                    report_error($sformatf(
                        "result %0d: expected roll %0d pitch %0d active %0b, got %0d %0d %0b",
                        results_seen, want.roll, want.pitch, want.active,
                        got.roll, got.pitch, got.active));
            end
        end
    end

    // Drive output ready: long hold first, else random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:   begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        endcase
    endtask

    // Write one register; called at a falling edge while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            CFG_ASSIST_ENABLE: assist_on    = val[0];
            CFG_DEADBAND_US:   deadband     = val[DB_W-1:0];
            CFG_MAX_ANGLE:     angle_limit  = val[MAXANG_W-1:0];
            CFG_SLEW_RATE:     slew_per_sec = val[SLEW_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = CFG_DATA_W'($urandom);
    endtask

    task automatic set_config(logic en, logic [DB_W-1:0] db, logic [MAXANG_W-1:0] ma,
        logic [SLEW_W-1:0] sr);
        write_reg(CFG_ASSIST_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_DEADBAND_US, CFG_DATA_W'(db));
        write_reg(CFG_MAX_ANGLE, CFG_DATA_W'(ma));
        write_reg(CFG_SLEW_RATE, sr);
    endtask

    // Offer one item after a random gap; record its prediction on accept
    task automatic send_sample(logic [PULSE_W-1:0] roll, logic [PULSE_W-1:0] pitch,
        logic [TICKS_W-1:0] ticks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = IN_DATA_W'({$urandom, $urandom});
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {ticks, pitch, roll};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_setpoints.push_back(advance_setpoints(roll, pitch, ticks));
        items_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (pending_setpoints.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [PULSE_W-1:0] random_pulse();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return PULSE_W'($urandom_range(4095));
        if (pick < 25)
            return PULSE_W'(CENTRE_US - deadband - 2 + $urandom_range(2 * deadband + 4));
        return PULSE_W'($urandom_range(2000, 1000));
    endfunction

    function automatic logic [TICKS_W-1:0] random_ticks();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 50)
            return TICKS_W'($urandom_range(40, 1));
        if (pick < 80)
            return TICKS_W'($urandom_range(1000, 1));
        return TICKS_W'($urandom_range(65535));
    endfunction

    task automatic send_random_sample();
        logic [PULSE_W-1:0] r;
        logic [PULSE_W-1:0] p;
        logic [TICKS_W-1:0] t;
        r = random_pulse();
        p = random_pulse();
        t = random_ticks();
        send_sample(r, p, t);
    endtask

    // Assist off out of reset: targets stay at zero
    task automatic test_assist_off_hold();
        set_idle(IDLE_NONE);
        send_sample(12'd2000, 12'd1000, 16'd100);
        send_sample(12'd4095, 12'd0, 16'd0);
        wait_for_results();
    endtask

    // Field extremes, fallback ticks, deadband edges and register extremes
    task automatic test_directed_cases();
        write_reg(CFG_ASSIST_ENABLE, 16'd1);
        send_sample(12'd2000, 12'd1000, 16'd0);
        send_sample(12'd4095, 12'd0, 16'd65535);
        send_sample(12'd1500, 12'd1500, 16'd1);
        send_sample(12'd0, 12'd4095, 16'd65535);
        send_sample(12'd1525, 12'd1475, 16'd65535);
        send_sample(12'd1526, 12'd1474, 16'd65535);
        send_sample(12'd1500, 12'd1500, 16'd65535);
        wait_for_results();
        // zero slew: nothing moves
        write_reg(CFG_SLEW_RATE, 16'd0);
        send_sample(12'd2000, 12'd1000, 16'd500);
        wait_for_results();
        set_config(1'b1, 8'd0, 15'd23040, 16'd65535);
        send_sample(12'd2000, 12'd1000, 16'd65535);
        send_sample(12'd1000, 12'd2000, 16'd65535);
        send_sample(12'd1501, 12'd1499, 16'd1);
        wait_for_results();
        // widest deadband with an angle limit above the nominal range
        set_config(1'b1, 8'd255, 15'd32767, 16'd65535);
        send_sample(12'd1755, 12'd1245, 16'd65535);
        send_sample(12'd1756, 12'd1244, 16'd65535);
        send_sample(12'd4095, 12'd0, 16'd65535);
        wait_for_results();
        write_reg(CFG_MAX_ANGLE, 16'd0);
        send_sample(12'd2000, 12'd1000, 16'd65535);
        wait_for_results();
        // disable assist between samples: targets hold
        set_config(1'b1, 8'd25, 15'd7680, 16'd20480);
        send_sample(12'd2000, 12'd1000, 16'd65535);
        wait_for_results();
        write_reg(CFG_ASSIST_ENABLE, 16'd0);
        send_sample(12'd1500, 12'd1500, 16'd10);
        wait_for_results();
    endtask

    // Stall the output long enough that the input backs up
    task automatic test_backpressure();
        set_idle(IDLE_NONE);
        set_config(1'b1, 8'd25, 15'd7680, 16'd4000);
        hold_left = 500;
        repeat (16) send_random_sample();
        wait_for_results();
    endtask

    // Random samples over several register settings and idle patterns
    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < 8; ph++)
        begin
            n = 140;
            set_idle(idle_mode_t'(ph % 4));
            case (ph)
                0: set_config(1'b1, 8'd0, 15'd23040, 16'd65535);
                1: set_config(1'b1, 8'd255, MAXANG_W'($urandom_range(23040)),
                              SLEW_W'($urandom_range(3000)));
                2: set_config(1'b1, 8'd250, 15'd32767, SLEW_W'($urandom_range(65535)));
                3:
                begin
                    set_config(1'b0, DB_W'($urandom_range(255)),
                               MAXANG_W'($urandom_range(23040)),
                               SLEW_W'($urandom_range(65535)));
                    n = 40;
                end
                default:
                    set_config(1'b1, DB_W'($urandom_range(255)),
                               MAXANG_W'($urandom_range(23040)),
                               ($urandom_range(1) != 0) ? SLEW_W'($urandom_range(4000))
                                                        : SLEW_W'($urandom_range(65535)));
            endcase
            repeat (n) send_random_sample();
            wait_for_results();
        end
    endtask

    // Main sequence
    initial
    begin : main_seq
        int waited;
        assist_on    = 1'b0;
        deadband     = DEADBAND_RST;
        angle_limit  = MAX_ANGLE_RST;
        slew_per_sec = SLEW_RATE_RST;
        roll_tgt     = '0;
        pitch_tgt    = '0;
        rst_n        = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_assist_off_hold();
        test_directed_cases();
        test_backpressure();
        test_random_phases();

        // Drain, then let the pipeline settle
        s_tvalid = 1'b0;
        waited   = 0;
        while (pending_setpoints.size() != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (150) @(negedge clk);
        if (pending_setpoints.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                                   pending_setpoints.size()));

        $display("Sent %0d stick samples, checked %0d setpoint results, %0d register writes,",
                 items_sent, results_seen, cfg_writes);
        $display("across four idle patterns, one long output stall and %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung run
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
